// ===== rtl/core/voxel_occupancy_inlier_counter_unit_assert.svh =====
// Assertion macros used by the checker file of this block.
// Implications checked while reset is released, and a next-cycle
// implication that is also checked during reset.
`ifndef VOXEL_OCCUPANCY_INLIER_COUNTER_UNIT_ASSERT_SVH
`define VOXEL_OCCUPANCY_INLIER_COUNTER_UNIT_ASSERT_SVH

`define VOCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define VOCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`define VOCC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/vocc_pkg.sv =====
// ----------------------------------------------------------------------------
// vocc_pkg
// Types, codes and constants of the voxel occupancy inlier counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vocc_pkg;

  localparam int TableEntriesDef = 4096;
  localparam int IndexBitsDef    = 16;
  localparam int ProbeLimitDef   = 16;
  localparam logic [31:0] IlsResetVal = 32'd6553600;
  localparam int OccBits = 13;

  // Low 48 bits of the multiplicative hash constant, as two 24-bit halves.
  localparam logic [23:0] HashCLo = 24'h4A7C15;
  localparam logic [23:0] HashCHi = 24'h79B97F;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_VOX, B_HASH1, B_HASH2, B_READ, B_CMP, B_CLEAR
  } back_state_t;

  // Neighbor offsets as {dz, dy, dx}.
  localparam logic [2:0] VoxOffs [8] = '{
    3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b110, 3'b101, 3'b111
  };

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  status;
    logic [31:0] inlier_total;
    logic [31:0] query_total;
    logic [12:0] occupied_entries;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/vocc_ram.sv =====
// ----------------------------------------------------------------------------
// vocc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vocc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vocc_fifo.sv =====
// ----------------------------------------------------------------------------
// vocc_fifo
// Short queue between the classifying front end and the table sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vocc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vocc_front.sv =====
// ----------------------------------------------------------------------------
// vocc_front
// Accepts items, scales the point and turns each axis into a voxel index
// with range flags for the index itself and for its +1 neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vocc_front import vocc_pkg::*; #(
  parameter int INDEX_BITS = IndexBitsDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         push,
  output logic                              full,
  input  wire in_item_t                     in_data,
  input  wire logic                         hold,
  output logic                              q_push,
  output logic [8+3*INDEX_BITS-1:0]         q_data,
  input  wire logic                         q_full
);

  localparam logic signed [33:0] Lim = 34'(1) << (INDEX_BITS - 1);

  logic [31:0] ils_r;
  logic s1_valid_r, s1_valid_nxt;
  logic [1:0] cmd_r;
  logic signed [63:0] prod_r [3];
  logic signed [31:0] coord [3];
  logic signed [64:0] prod [3];
  logic accept;
  logic [2:0] ok0, ok1;
  logic [INDEX_BITS-1:0] idx_lo [3];

  function automatic logic idx_ok(input logic signed [33:0] v);
    idx_ok = (v >= -Lim) && (v < Lim);
  endfunction

  assign full   = hold || (s1_valid_r && q_full);
  assign accept = push && !full;
  assign q_push = s1_valid_r && !q_full;

  assign coord[0] = in_data.coord_x;
  assign coord[1] = in_data.coord_y;
  assign coord[2] = in_data.coord_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = coord[a] * $signed({1'b0, ils_r});
    end
  end

  // Floor for inserts; round half to even for queries.
  always_comb begin
    logic signed [31:0] q;
    logic [31:0] f;
    logic up;
    logic signed [33:0] v;
    for (int a = 0; a < 3; a++) begin
      q = prod_r[a][63:32];
      f = prod_r[a][31:0];
      up = (cmd_r == CMD_QUERY) &&
           ((f > 32'h8000_0000) || ((f == 32'h8000_0000) && q[0]));
      v = 34'(q) + 34'(up);
      ok0[a] = idx_ok(v);
      ok1[a] = idx_ok(v + 34'sd1);
      idx_lo[a] = v[INDEX_BITS-1:0];
    end
  end

  assign q_data = {cmd_r, ok1, ok0, idx_lo[2], idx_lo[1], idx_lo[0]};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ils_r      <= IlsResetVal;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        ils_r <= cfg_data;
      end
    end
    if (accept) begin
      cmd_r <= in_data.command;
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= prod[a][63:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vocc_back.sv =====
// ----------------------------------------------------------------------------
// vocc_back
// Table sequencer: hashes each voxel key, probes the set linearly, inserts
// or looks up, keeps the counters and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vocc_back import vocc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int INDEX_BITS    = IndexBitsDef,
  parameter int PROBE_LIMIT   = ProbeLimitDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  output logic                            hold,
  input  wire logic [8+3*INDEX_BITS-1:0]  q_data,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output out_item_t                       out_data
);

  localparam int IB = INDEX_BITS;
  localparam int KW = 3 * IB;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(PROBE_LIMIT) + 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  back_state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [KW-1:0] base_r, base_nxt, key_r, key_nxt;
  logic [2:0] ok0_r, ok0_nxt, ok1_r, ok1_nxt, k_r, k_nxt;
  logic [47:0] p0_r, p1a_r, p1b_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] probe_r, probe_nxt;
  logic hit_r, hit_nxt, bad_r, bad_nxt, ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] hits_r, hits_nxt, qrys_r, qrys_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic done, ready_out;
  logic we, re;
  logic [KW:0] wdata, rdata;
  logic [63:0] key64;
  logic [47:0] hash;
  logic [KW-1:0] vox_key;
  logic vox_ok;
  logic [31:0] cnt_ext;

  vocc_ram #(.WIDTH(KW + 1), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .re    (re),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign hold      = (state_r == B_INIT);
  assign empty     = !out_valid_r;
  assign out_data  = out_r;
  assign ready_out = !out_valid_r || pop;

  assign key64 = 64'(key_r);
  assign hash  = p0_r + ((p1a_r + p1b_r) << 24);
  assign cnt_ext = 32'(cnt_r);

  // Key and range flag of the current neighbor.
  always_comb begin
    logic [2:0] off;
    off = VoxOffs[k_r];
    vox_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      vox_key[a*IB +: IB] = base_r[a*IB +: IB] + IB'(off[a]);
      vox_ok = vox_ok && (off[a] ? ok1_r[a] : ok0_r[a]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    base_nxt  = base_r;
    ok0_nxt   = ok0_r;
    ok1_nxt   = ok1_r;
    k_nxt     = k_r;
    key_nxt   = key_r;
    addr_nxt  = addr_r;
    probe_nxt = probe_r;
    hit_nxt   = hit_r;
    bad_nxt   = bad_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    hits_nxt  = hits_r;
    qrys_nxt  = qrys_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    wdata     = '0;
    done      = 1'b0;
    unique case (state_r)
      B_INIT: begin
        we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(TABLE_ENTRIES - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_data[KW+7:KW+6];
          ok1_nxt  = q_data[KW+5:KW+3];
          ok0_nxt  = q_data[KW+2:KW];
          base_nxt = q_data[KW-1:0];
          k_nxt    = '0;
          hit_nxt  = 1'b0;
          bad_nxt  = 1'b0;
          addr_nxt = '0;
          unique case (q_data[KW+7:KW+6])
            CMD_CLEAR:  state_nxt = B_CLEAR;
            CMD_REPORT: state_nxt = B_IDLE;
            default:    state_nxt = B_VOX;
          endcase
          if (q_data[KW+7:KW+6] == CMD_REPORT) begin
            state_nxt = B_CLEAR;
          end
        end
      end
      B_VOX: begin
        if (vox_ok) begin
          key_nxt   = vox_key;
          state_nxt = B_HASH1;
        end else begin
          bad_nxt = 1'b1;
          if (cmd_r == CMD_INSERT && k_r != 3'd7) begin
            k_nxt = k_r + 1'b1;
          end else begin
            state_nxt = B_CLEAR;
          end
        end
      end
      B_HASH1: begin
        state_nxt = B_HASH2;
      end
      B_HASH2: begin
        addr_nxt  = hash[32 +: AW];
        probe_nxt = '0;
        state_nxt = B_READ;
      end
      B_READ: begin
        re = 1'b1;
        state_nxt = B_CMP;
      end
      B_CMP: begin
        if (!rdata[KW] || rdata[KW-1:0] == key_r ||
            probe_r == PW'(PROBE_LIMIT - 1)) begin
          if (!rdata[KW]) begin
            if (cmd_r == CMD_INSERT) begin
              we = 1'b1;
              wdata = {1'b1, key_r};
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (rdata[KW-1:0] == key_r) begin
            hit_nxt = (cmd_r == CMD_QUERY);
          end else if (cmd_r == CMD_INSERT) begin
            ovf_nxt = 1'b1;
          end
          if (cmd_r == CMD_INSERT && k_r != 3'd7) begin
            k_nxt = k_r + 1'b1;
            state_nxt = B_VOX;
          end else begin
            state_nxt = B_CLEAR;
          end
        end else begin
          addr_nxt  = addr_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = B_READ;
        end
      end
      // Doubles as the result stage: a clear sweeps the table first, every
      // other command lands here only to deliver its result.
      B_CLEAR: begin
        if (cmd_r == CMD_CLEAR && !(addr_r == AW'(TABLE_ENTRIES - 1) && k_r[0])) begin
          we = 1'b1;
          addr_nxt = addr_r + 1'b1;
          if (addr_r == AW'(TABLE_ENTRIES - 1)) begin
            // Stay on the last entry so that the result is delivered as soon as the result register is free.
            addr_nxt = addr_r;
            k_nxt    = 3'd1;
            cnt_nxt  = '0;
            hits_nxt = '0;
            qrys_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end else if (ready_out) begin
          done = 1'b1;
          if (cmd_r == CMD_QUERY) begin
            if (qrys_r != '1) begin
              qrys_nxt = qrys_r + 1'b1;
            end
            if (hit_r && hits_r != '1) begin
              hits_nxt = hits_r + 1'b1;
            end
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_nxt.hit              = hit_r;
    out_nxt.status           = bad_r ? ST_RANGE : (ovf_r ? ST_OVERFLOW : ST_OK);
    out_nxt.inlier_total     = hits_nxt;
    out_nxt.query_total      = qrys_nxt;
    out_nxt.occupied_entries = cnt_ext[OccBits-1:0];
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      addr_r      <= '0;
      cnt_r       <= '0;
      hits_r      <= '0;
      qrys_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      hits_r      <= hits_nxt;
      qrys_r      <= qrys_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r   <= cmd_nxt;
    base_r  <= base_nxt;
    ok0_r   <= ok0_nxt;
    ok1_r   <= ok1_nxt;
    k_r     <= k_nxt;
    key_r   <= key_nxt;
    probe_r <= probe_nxt;
    hit_r   <= hit_nxt;
    bad_r   <= bad_nxt;
    p0_r    <= 48'(key64[23:0] * HashCLo);
    p1a_r   <= 48'(key64[47:24] * HashCLo);
    p1b_r   <= 48'(key64[23:0] * HashCHi);
    if (done) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/voxel_occupancy_inlier_counter_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_inlier_counter_unit
// Voxel occupancy hash set with query inlier counting.
// ----------------------------------------------------------------------------
// Usage: items enter through push/full as in_data (command and a Q15.16
// point); every item yields one result, read through empty/pop as out_data.
// cfg_we/cfg_data write inverse_leaf_size while the block is idle.
// The front end scales a point into a register, classifies it and parks it in
// a four-deep queue; the back end works one item at a time against a
// single-port-read table RAM. Hashing passes through B_HASH1 and B_HASH2,
// and each probe reads an entry (B_READ) and compares it (B_CMP); a query
// probes one voxel, an insert the eight neighbor voxels, a report none.
// A clear sweeps the table one entry a cycle and delivers its result once
// the sweep is done and the result register is free.
// After reset the same sweep runs over every entry with full high.
// The result register holds a result until it is popped; the back end then
// waits, the queue fills and full rises.
// TABLE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_inlier_counter_unit import vocc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int INDEX_BITS    = IndexBitsDef,
  parameter int PROBE_LIMIT   = ProbeLimitDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_data,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  localparam int QW = 8 + 3 * INDEX_BITS;

  logic hold, q_wr, q_full, q_rd, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  vocc_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .hold     (hold),
    .q_push   (q_wr),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  vocc_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  vocc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .INDEX_BITS    (INDEX_BITS),
    .PROBE_LIMIT   (PROBE_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold     (hold),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vocc_checker.sv =====
// ----------------------------------------------------------------------------
// vocc_checker
// Port-level checks of the voxel occupancy inlier counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_occupancy_inlier_counter_unit_assert.svh"

module vocc_checker import vocc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data
);

  // A result that is not taken stays on the ports unchanged.
  `VOCC_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_data))
  // A hit always shows in the inlier count.
  `VOCC_ASSERT_IMP(a_hit_cnt, clk, rst_n, !empty && out_data.hit, out_data.inlier_total != 0)
  // Inliers never outnumber queries.
  `VOCC_ASSERT_IMP(a_ratio, clk, rst_n, !empty, out_data.inlier_total <= out_data.query_total)
  // Nothing is offered in the cycle after a reset edge.
  `VOCC_ASSERT_ALWAYS(a_rst, clk, !rst_n, empty)

endmodule

bind voxel_occupancy_inlier_counter_unit vocc_checker u_vocc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire
